### hw/rtl/wbs_pkg.sv
package wbs_pkg;

   localparam int ROW_W   = 14;
   localparam int HIT_W   = 26;
   localparam int SUM_W   = 40;
   localparam int MAG_W   = SUM_W - 1;
   localparam int DEN_W   = HIT_W + ROW_W;
   localparam int QUO_W   = 14;
   localparam int TURN_W  = 16;
   localparam int STEP_W  = $clog2(QUO_W);

   localparam logic [ROW_W-1:0]        ROW_RESET   = 14'd2400;
   localparam logic [ROW_W-1:0]        ROW_MIN     = 14'd3;
   localparam logic [HIT_W-1:0]        HIT_MAX     = {HIT_W{1'b1}};
   localparam logic signed [SUM_W:0]   SUM_HI      = 41'sh7F_FFFF_FFFF;
   localparam logic signed [SUM_W:0]   SUM_LO      = -41'sh7F_FFFF_FFFF;
   localparam logic [QUO_W:0]          TURN_LIMIT  = 15'd16384;
   localparam logic [TURN_W-1:0]       SEARCH_TURN = 16'd2048;
   localparam logic [7:0]              WHITE       = 8'd255;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CMP,
      ST_DIV,
      ST_FIN
   } state_type;

endpackage

### hw/rtl/white_blob_steering_unit.sv
// Ordinary bytes: one per cycle, req_stall stays low.
// Frame-end byte: accumulators update in its accept cycle, then a multiply state (ST_MUL),
// a compare state (ST_CMP) and a restoring divider (ST_DIV, one quotient bit per cycle).
// The result register loads in ST_FIN, reached from ST_MUL (no hits), from ST_CMP (clamped turn)
// or after ST_DIV; input is stalled until then, and longer if the previous result is held.
// Synchronous active-high reset: row length 2400, accumulators and column cleared.
module white_blob_steering_unit #(
   parameter int MAX_ROW_BYTES = 8192
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [wbs_pkg::ROW_W-1:0]          csr_row_bytes,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_pixel_byte,
   input  logic                               req_frame_end,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_drive_forward,
   output logic signed [wbs_pkg::TURN_W-1:0]  rsp_turn_rate
);
   import wbs_pkg::*;

   localparam int COL_W = (MAX_ROW_BYTES > 2) ? $clog2(MAX_ROW_BYTES) : 2;

   state_type          state_ff, state_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               prev_ff, prev_in;
   logic               prev2_ff, prev2_in;
   logic [COL_W-1:0]   column_ff, column_in;
   logic [HIT_W-1:0]   hit_ff, hit_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [MAG_W:0]     rem_ff, rem_in;
   logic [QUO_W:0]     quo_ff, quo_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               neg_ff, neg_in;
   logic               fwd_ff, fwd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_fwd_ff, rsp_fwd_in;
   logic [TURN_W-1:0]  rsp_turn_ff, rsp_turn_in;

   logic [ROW_W-1:0]   r_eff;
   logic               accept;
   logic               white;
   logic               hit;
   logic signed [31:0] win_offset;
   logic signed [SUM_W:0] sum_wide;
   logic [DEN_W:0]     rem_sh;
   logic [TURN_W-1:0]  mag_turn;

   always_comb begin
      if (row_ff < ROW_MIN) begin
         r_eff = ROW_MIN;
      end else if (32'(row_ff) > MAX_ROW_BYTES) begin
         r_eff = ROW_W'(MAX_ROW_BYTES);
      end else begin
         r_eff = row_ff;
      end
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign accept            = req_valid && !req_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_forward = rsp_fwd_ff;
   assign rsp_turn_rate     = rsp_turn_ff;

   always_comb begin
      white    = (req_pixel_byte == WHITE);
      hit      = white && prev_ff && prev2_ff && (column_ff >= COL_W'(2));
      // twice the window start's distance from the row center
      win_offset = 2 * (int'(column_ff) - 2) - int'(r_eff);
      sum_wide = {sum_ff[SUM_W-1], sum_ff} + (SUM_W+1)'(win_offset);
      rem_sh   = {rem_ff, 1'b0};
      mag_turn = TURN_W'(quo_ff);

      state_in     = state_ff;
      row_in       = row_ff;
      prev_in      = prev_ff;
      prev2_in     = prev2_ff;
      column_in    = column_ff;
      hit_in       = hit_ff;
      sum_in       = sum_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      fwd_in       = fwd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_fwd_in   = rsp_fwd_ff;
      rsp_turn_in  = rsp_turn_ff;

      if (csr_write_enable) begin
         row_in = csr_row_bytes;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (hit) begin
                  if (hit_ff != HIT_MAX) begin
                     hit_in = hit_ff + HIT_W'(1);
                  end
                  if (sum_wide > SUM_HI) begin
                     sum_in = SUM_W'(SUM_HI);
                  end else if (sum_wide < SUM_LO) begin
                     sum_in = SUM_W'(SUM_LO);
                  end else begin
                     sum_in = SUM_W'(sum_wide);
                  end
               end
               if (int'(column_ff) + 1 >= int'(r_eff)) begin
                  column_in = '0;
                  prev_in   = 1'b0;
                  prev2_in  = 1'b0;
               end else begin
                  column_in = COL_W'(int'(column_ff) + 1);
                  prev2_in  = prev_ff;
                  prev_in   = white;
               end
               if (req_frame_end) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            den_in = DEN_W'(hit_ff) * DEN_W'(r_eff);
            rem_in = sum_ff[SUM_W-1] ? (MAG_W+1)'(-sum_ff) : (MAG_W+1)'(sum_ff);
            neg_in = !sum_ff[SUM_W-1] && (sum_ff != '0);
            fwd_in = (hit_ff != '0);
            state_in = (hit_ff != '0) ? ST_CMP : ST_FIN;
         end
         ST_CMP: begin
            // |sum| >= den means the quotient reaches the turn limit
            if (DEN_W'(rem_ff) >= den_ff) begin
               quo_in   = TURN_LIMIT;
               state_in = ST_FIN;
            end else begin
               quo_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = (MAG_W+1)'(rem_sh - {1'b0, den_ff});
               quo_in = {quo_ff[QUO_W-1:0], 1'b1};
            end else begin
               rem_in = (MAG_W+1)'(rem_sh);
               quo_in = {quo_ff[QUO_W-1:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(QUO_W - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_fwd_in   = fwd_ff;
               if (!fwd_ff) begin
                  rsp_turn_in = SEARCH_TURN;
               end else if (neg_ff) begin
                  rsp_turn_in = -mag_turn;
               end else begin
                  rsp_turn_in = mag_turn;
               end
               prev_in   = 1'b0;
               prev2_in  = 1'b0;
               column_in = '0;
               hit_in    = '0;
               sum_in    = '0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= ROW_RESET;
         prev_ff      <= 1'b0;
         prev2_ff     <= 1'b0;
         column_ff    <= '0;
         hit_ff       <= '0;
         sum_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         prev_ff      <= prev_in;
         prev2_ff     <= prev2_in;
         column_ff    <= column_in;
         hit_ff       <= hit_in;
         sum_ff       <= sum_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      fwd_ff      <= fwd_in;
      rsp_fwd_ff  <= rsp_fwd_in;
      rsp_turn_ff <= rsp_turn_in;
   end

endmodule

### tb/sv/tb_white_blob_steering_unit.sv
module tb_white_blob_steering_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import wbs_pkg::*;

   localparam int MAX_ROW         = 8192;
   localparam int SETTLE_CYCLES   = 24;     // slowest result is the one that runs the full divide
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CYCLE_LIMIT     = 200000;

   typedef struct packed {
      logic                     drive_forward;
      logic signed [TURN_W-1:0] turn_rate;
   } steer_cmd_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_write_enable = 1'b0;
   logic [ROW_W-1:0]         csr_row_bytes = '0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [7:0]               req_pixel_byte = '0;
   logic                     req_frame_end = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_drive_forward;
   logic signed [TURN_W-1:0] rsp_turn_rate;

   // shadow of the block's state
   logic [ROW_W-1:0] row_len_cfg = ROW_RESET;
   bit               trk_prev_white;
   bit               trk_prev2_white;
   int unsigned      trk_column;
   longint           trk_hits;
   longint           trk_offset;
   steer_cmd_type    steer_expected[$];

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_left = 0;
   int pixels_sent = 0;
   int mismatches = 0;
   int cycle_count = 0;

   white_blob_steering_unit #(
      .MAX_ROW_BYTES(MAX_ROW)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_row_bytes     (csr_row_bytes),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel_byte    (req_pixel_byte),
      .req_frame_end     (req_frame_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_drive_forward (rsp_drive_forward),
      .rsp_turn_rate     (rsp_turn_rate)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int effective_row(input logic [ROW_W-1:0] v);
      int r;
      r = int'(v);
      if (r < int'(ROW_MIN)) r = int'(ROW_MIN);
      if (r > MAX_ROW) r = MAX_ROW;
      return r;
   endfunction

   // scan one byte, update accumulators, and queue the steering command on frame end
   function automatic void track_blob_pixel(input logic [7:0] pix, input logic fe);
      int            r;
      bit            white;
      longint        win_offset;
      longint        quo;
      steer_cmd_type cmd;
      r = effective_row(row_len_cfg);
      white = (pix == WHITE);
      if (white && trk_prev_white && trk_prev2_white && trk_column >= 2) begin
         win_offset = 2 * (longint'(trk_column) - 2) - r;
         if (trk_hits < longint'(HIT_MAX)) trk_hits++;
         trk_offset += win_offset;
         if (trk_offset > longint'(SUM_HI)) trk_offset = longint'(SUM_HI);
         if (trk_offset < longint'(SUM_LO)) trk_offset = longint'(SUM_LO);
      end
      if (trk_column + 1 >= r) begin
         trk_column = 0;
         trk_prev_white = 1'b0;
         trk_prev2_white = 1'b0;
      end else begin
         trk_column++;
         trk_prev2_white = trk_prev_white;
         trk_prev_white = white;
      end
      if (fe) begin
         if (trk_hits == 0) begin
            cmd.drive_forward = 1'b0;
            cmd.turn_rate = SEARCH_TURN;
         end else begin
            quo = (-16384 * trk_offset) / (trk_hits * r);
            if (quo > longint'(TURN_LIMIT)) quo = longint'(TURN_LIMIT);
            if (quo < -longint'(TURN_LIMIT)) quo = -longint'(TURN_LIMIT);
            cmd.drive_forward = 1'b1;
            cmd.turn_rate = quo[TURN_W-1:0];
         end
         steer_expected.push_back(cmd);
         trk_prev_white = 1'b0;
         trk_prev2_white = 1'b0;
         trk_column = 0;
         trk_hits = 0;
         trk_offset = 0;
      end
   endfunction

   function automatic logic [ROW_W-1:0] pick_row_len();
      case ($urandom_range(9))
         0: return ROW_W'($urandom_range(0, 3));
         1: return ($urandom_range(1) == 1) ? ROW_W'(MAX_ROW)
                                             : ROW_W'($urandom_range(MAX_ROW + 1, 16383));
         2: return ROW_W'($urandom_range(25, MAX_ROW - 1));
         default: return ROW_W'($urandom_range(3, 24));
      endcase
   endfunction

   task automatic send_pixel(input logic [7:0] pix, input logic fe);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_byte <= pix;
      req_frame_end <= fe;
      do @(posedge clock); while (!(req_valid && !req_stall));
      track_blob_pixel(pix, fe);
      pixels_sent++;
   endtask

   task automatic send_frame(input int len);
      logic [7:0] pix;
      for (int i = 0; i < len; i++) begin
         pix = ($urandom_range(99) < 55) ? WHITE : 8'($urandom);
         send_pixel(pix, i == len - 1);
      end
   endtask

   // stop offering items and let every outstanding result come out
   task automatic quiesce();
      req_valid <= 1'b0;
      while (steer_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_row_len(input logic [ROW_W-1:0] v);
      csr_write_enable <= 1'b1;
      csr_row_bytes <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      row_len_cfg = v;
   endtask

   task automatic test_reset_row_length();
      send_pixel(8'h00, 1'b1);
      send_pixel(WHITE, 1'b0);
      send_pixel(WHITE, 1'b0);
      send_pixel(WHITE, 1'b1);
   endtask

   task automatic test_clamped_row_length();
      quiesce();
      write_row_len(14'd0);
      // six whites in rows of three: no window straddles the row break
      repeat (5) send_pixel(WHITE, 1'b0);
      send_pixel(WHITE, 1'b1);
      quiesce();
      write_row_len(14'd16383);
      send_pixel(8'h07, 1'b0);
      send_pixel(WHITE, 1'b0);
      send_pixel(WHITE, 1'b0);
      send_pixel(WHITE, 1'b1);
   endtask

   task automatic test_right_half_window();
      quiesce();
      write_row_len(14'd7);
      send_pixel(8'hFE, 1'b0);
      send_pixel(8'h01, 1'b0);
      send_pixel(8'h80, 1'b0);
      send_pixel(8'h00, 1'b0);
      send_pixel(WHITE, 1'b0);
      send_pixel(WHITE, 1'b0);
      send_pixel(WHITE, 1'b1);
   endtask

   task automatic test_mid_row_shrink();
      quiesce();
      write_row_len(14'd7);
      repeat (5) send_pixel(8'h00, 1'b0);
      quiesce();
      // column now past the new row end: next item closes the row
      write_row_len(14'd4);
      send_pixel(WHITE, 1'b0);
      send_pixel(WHITE, 1'b0);
      send_pixel(WHITE, 1'b0);
      send_pixel(WHITE, 1'b1);
   endtask

   task automatic test_result_backpressure();
      quiesce();
      write_row_len(14'd5);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_left = HOLD_OFF_CYCLES;
      repeat (40) send_frame($urandom_range(1, 6));
      quiesce();
   endtask

   task automatic test_random_frames(input int sender_pct, input int receiver_pct,
                                     input logic [ROW_W-1:0] first_len, input int count);
      int               stop_at;
      int               r;
      int               span;
      logic [ROW_W-1:0] len_val;
      req_idle_pct = sender_pct;
      rsp_idle_pct = receiver_pct;
      stop_at = pixels_sent + count;
      len_val = first_len;
      while (pixels_sent < stop_at) begin
         quiesce();
         write_row_len(len_val);
         r = effective_row(len_val);
         span = (3 * r < 48) ? 3 * r : 48;
         repeat ($urandom_range(2, 6)) send_frame($urandom_range(1, span));
         len_val = pick_row_len();
      end
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin : check_steering
      steer_cmd_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (steer_expected.size() == 0) begin
            $error("unexpected item: drive_forward %0d turn_rate %0d",
                   rsp_drive_forward, rsp_turn_rate);
            mismatches++;
         end else begin
            want = steer_expected.pop_front();
            if (rsp_drive_forward !== want.drive_forward) begin
               $error("drive_forward: expected %0d, actual %0d",
                      want.drive_forward, rsp_drive_forward);
               mismatches++;
            end
            if (rsp_turn_rate !== want.turn_rate) begin
               $error("turn_rate: expected %0d, actual %0d", want.turn_rate, rsp_turn_rate);
               mismatches++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_row_length();
      test_clamped_row_length();
      test_right_half_window();
      test_mid_row_shrink();
      test_result_backpressure();
      test_random_frames(24, 73, ROW_W'(MAX_ROW), 360);
      test_random_frames(73, 24, 14'd2, 360);
      test_random_frames(0, 0, 14'd3, 360);
      quiesce();
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/wbs_pkg.sv
hw/rtl/white_blob_steering_unit.sv
tb/sv/tb_white_blob_steering_unit.sv
